/* sv/bsc_pkg.sv */
// Shared types, register indexes and the control program of the barometric
// sensor compensation block. No dependencies.
package bsc_pkg;

  // Widths of the fixed fields and internal words
  localparam int RAW_W   = 24;
  localparam int COEF_W  = 16;
  localparam int RES_W   = 25;
  localparam int TD_W    = 25;
  localparam int MA_W    = 25;
  localparam int MB_W    = 19;
  localparam int PROD_W  = 44;
  localparam int OFF_W   = 36;
  localparam int SENS_W  = 35;
  localparam int ACC_W   = 60;
  localparam int IDX_W   = 3;
  localparam int STEP_W  = 4;

  // Temperature offset in centidegrees
  localparam logic [RES_W-1:0] TEMP_BASE = 25'd2000;

  // Configuration register indexes
  typedef enum logic [IDX_W-1:0] {
    REG_SENS_COEF        = 3'd0,
    REG_OFFSET_COEF      = 3'd1,
    REG_SENS_TEMP_COEF   = 3'd2,
    REG_OFFSET_TEMP_COEF = 3'd3,
    REG_REF_TEMPERATURE  = 3'd4,
    REG_TEMP_SENSITIVITY = 3'd5
  } reg_idx_t;

  // Item kinds
  localparam logic KIND_TEMP = 1'b0;
  localparam logic KIND_PRES = 1'b1;

  // Multiplier operand pairs
  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_TEMP,
    MUL_OTC,
    MUL_STC,
    MUL_SHI,
    MUL_SLO
  } mul_sel_t;

  // Register-update operations
  typedef enum logic [3:0] {
    ALU_NOP,
    ALU_TD,
    ALU_OFF,
    ALU_SENS,
    ALU_ACC_LD,
    ALU_ACC_ADD,
    ALU_ACC_SUB,
    ALU_TEMP_RES,
    ALU_PRES_RES
  } alu_op_t;

  // Sequencing of the next step
  typedef enum logic [1:0] {
    JMP_NEXT,
    JMP_PRES,
    JMP_DONE
  } jmp_t;

  typedef struct packed {
    mul_sel_t          mul_sel;
    alu_op_t           alu_op;
    jmp_t              jmp;
    logic [STEP_W-1:0] target;
  } ucode_t;

  // Sequencer to datapath control group
  typedef struct packed {
    logic     load;
    logic     exec;
    logic     commit;
    mul_sel_t mul_sel;
    alu_op_t  alu_op;
  } dp_ctl_t;

  localparam logic [STEP_W-1:0] PRES_ENTRY = 4'd4;

  // Control program: temperature runs steps 0..3, pressure 0 then 4..11
  function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
    ucode_t w;
    w = '{mul_sel: MUL_NONE, alu_op: ALU_NOP, jmp: JMP_DONE, target: '0};
    case (step)
      4'd0:  w = '{mul_sel: MUL_NONE, alu_op: ALU_NOP,      jmp: JMP_PRES, target: PRES_ENTRY};
      4'd1:  w = '{mul_sel: MUL_NONE, alu_op: ALU_TD,       jmp: JMP_NEXT, target: '0};
      4'd2:  w = '{mul_sel: MUL_TEMP, alu_op: ALU_NOP,      jmp: JMP_NEXT, target: '0};
      4'd3:  w = '{mul_sel: MUL_NONE, alu_op: ALU_TEMP_RES, jmp: JMP_DONE, target: '0};
      4'd4:  w = '{mul_sel: MUL_OTC,  alu_op: ALU_NOP,      jmp: JMP_NEXT, target: '0};
      4'd5:  w = '{mul_sel: MUL_STC,  alu_op: ALU_OFF,      jmp: JMP_NEXT, target: '0};
      4'd6:  w = '{mul_sel: MUL_NONE, alu_op: ALU_SENS,     jmp: JMP_NEXT, target: '0};
      4'd7:  w = '{mul_sel: MUL_SHI,  alu_op: ALU_NOP,      jmp: JMP_NEXT, target: '0};
      4'd8:  w = '{mul_sel: MUL_SLO,  alu_op: ALU_ACC_LD,   jmp: JMP_NEXT, target: '0};
      4'd9:  w = '{mul_sel: MUL_NONE, alu_op: ALU_ACC_ADD,  jmp: JMP_NEXT, target: '0};
      4'd10: w = '{mul_sel: MUL_NONE, alu_op: ALU_ACC_SUB,  jmp: JMP_NEXT, target: '0};
      4'd11: w = '{mul_sel: MUL_NONE, alu_op: ALU_PRES_RES, jmp: JMP_DONE, target: '0};
      default: w = '{mul_sel: MUL_NONE, alu_op: ALU_NOP,    jmp: JMP_DONE, target: '0};
    endcase
    return w;
  endfunction

endpackage

/* sv/bsc_seq.sv */
// Microcode sequencer: step counter, control program lookup, item handshake
// and result valid flag. Depends on bsc_pkg.
module bsc_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  logic             is_pres,
  output bsc_pkg::dp_ctl_t ctl
);
  import bsc_pkg::*;

  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;
  ucode_t            uw;
  logic              accept;
  logic              stall;
  logic              finish;

  assign uw       = ucode_rom(step_r);
  assign in_ready = !busy_r;
  assign accept   = in_valid && in_ready;
  // hold the last step while the previous result is still waiting
  assign stall    = busy_r && (uw.jmp == JMP_DONE) && out_valid_r && !out_ready;
  assign finish   = busy_r && (uw.jmp == JMP_DONE) && !stall;
  assign out_valid = out_valid_r;

  // Drive the datapath from the current control word
  always_comb begin
    ctl.load    = accept;
    ctl.exec    = busy_r && !stall;
    ctl.commit  = finish;
    ctl.mul_sel = uw.mul_sel;
    ctl.alu_op  = uw.alu_op;
  end

  // Advance the step counter, take jumps, retire items
  always_comb begin
    busy_nxt      = busy_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (accept) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end else if (busy_r && !stall) begin
      case (uw.jmp)
        JMP_NEXT: step_nxt = step_r + 1'b1;
        JMP_PRES: step_nxt = is_pres ? uw.target : step_r + 1'b1;
        JMP_DONE: begin
          busy_nxt = 1'b0;
          step_nxt = '0;
        end
        default: step_nxt = '0;
      endcase
    end
    if (finish) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Idle sequencer always rests on the first step
  a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> step_r == '0)
    else $error("idle sequencer off step zero");

  // An accepted item starts the program at step zero
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r && step_r == '0)
    else $error("item accepted but program not started");

  // A retired item always leaves a result waiting
  a_commit: assert property (@(posedge clk) disable iff (!rst_n)
    finish |=> out_valid_r)
    else $error("result lost at retire");

  // A stalled final step keeps its place
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    stall |=> busy_r && $stable(step_r))
    else $error("final step moved while stalled");

endmodule

/* sv/bsc_dp.sv */
// Datapath: configuration registers, stored temperature difference, shared
// multiplier, accumulator and result register. Depends on bsc_pkg.
module bsc_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bsc_pkg::IDX_W-1:0]         cfg_index,
  input  logic [bsc_pkg::COEF_W-1:0]        cfg_wdata,
  input  logic                              in_req_type,
  input  logic [bsc_pkg::RAW_W-1:0]         in_raw_reading,
  input  bsc_pkg::dp_ctl_t                  ctl,
  output logic                              is_pres,
  output logic                              out_result_kind,
  output logic signed [bsc_pkg::RES_W-1:0]  out_result_value
);
  import bsc_pkg::*;

  // configuration
  logic [COEF_W-1:0] sens_coef_r, offset_coef_r, sens_temp_coef_r;
  logic [COEF_W-1:0] offset_temp_coef_r, ref_temperature_r, temp_sensitivity_r;

  // state and working registers
  logic signed [TD_W-1:0]   td_r, td_nxt;
  logic                     kind_r;
  logic [RAW_W-1:0]         raw_r;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic signed [OFF_W-1:0]  off_r, off_nxt;
  logic signed [SENS_W-1:0] sens_r, sens_nxt;
  logic signed [ACC_W-1:0]  acc_r, acc_nxt;
  logic                     res_kind_r;
  logic signed [RES_W-1:0]  res_r, res_nxt;

  logic                     big;
  logic signed [MA_W-1:0]   ma;
  logic signed [MB_W-1:0]   mb;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [PROD_W-1:0] off_sh, sens_sh, temp_sh;
  logic signed [ACC_W-1:0]  acc_sh21, acc_sh15;

  assign is_pres          = (kind_r == KIND_PRES);
  assign out_result_kind  = res_kind_r;
  assign out_result_value = res_r;

  // Write configuration registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sens_coef_r        <= '0;
      offset_coef_r      <= '0;
      sens_temp_coef_r   <= '0;
      offset_temp_coef_r <= '0;
      ref_temperature_r  <= '0;
      temp_sensitivity_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SENS_COEF:        sens_coef_r        <= cfg_wdata;
        REG_OFFSET_COEF:      offset_coef_r      <= cfg_wdata;
        REG_SENS_TEMP_COEF:   sens_temp_coef_r   <= cfg_wdata;
        REG_OFFSET_TEMP_COEF: offset_temp_coef_r <= cfg_wdata;
        REG_REF_TEMPERATURE:  ref_temperature_r  <= cfg_wdata;
        REG_TEMP_SENSITIVITY: temp_sensitivity_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Large differences take the halved operands and the shorter shift
  assign big = (td_r > $signed(25'd65535));

  // Select multiplier operands
  always_comb begin
    ma = '0;
    mb = '0;
    case (ctl.mul_sel)
      MUL_TEMP: begin
        ma = big ? (td_r >>> 1) : td_r;
        mb = big ? $signed({4'b0, temp_sensitivity_r[COEF_W-1:1]})
                 : $signed({3'b0, temp_sensitivity_r});
      end
      MUL_OTC: begin
        ma = td_r;
        mb = $signed({3'b0, offset_temp_coef_r});
      end
      MUL_STC: begin
        ma = td_r;
        mb = $signed({3'b0, sens_temp_coef_r});
      end
      MUL_SHI: begin
        ma = $signed({1'b0, raw_r});
        mb = $signed({{2{sens_r[SENS_W-1]}}, sens_r[SENS_W-1:18]});
      end
      MUL_SLO: begin
        ma = $signed({1'b0, raw_r});
        mb = $signed({1'b0, sens_r[17:0]});
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign prod_nxt = ma * mb;
  assign prod_ext = $signed({{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r});
  assign off_sh   = prod_r >>> 6;
  assign sens_sh  = prod_r >>> 7;
  assign temp_sh  = big ? (prod_r >>> 21) : (prod_r >>> 23);
  assign acc_sh21 = acc_r >>> 21;
  assign acc_sh15 = acc_r >>> 15;

  // Register updates selected by the control word
  always_comb begin
    td_nxt   = td_r;
    off_nxt  = off_r;
    sens_nxt = sens_r;
    acc_nxt  = acc_r;
    res_nxt  = res_r;
    case (ctl.alu_op)
      ALU_TD:
        td_nxt = $signed({1'b0, raw_r}) - $signed({1'b0, ref_temperature_r, 8'b0});
      ALU_OFF:
        off_nxt = $signed({3'b0, offset_coef_r, 17'b0}) + off_sh[OFF_W-1:0];
      ALU_SENS:
        sens_nxt = $signed({3'b0, sens_coef_r, 16'b0}) + sens_sh[SENS_W-1:0];
      ALU_ACC_LD:
        acc_nxt = $signed({prod_ext[ACC_W-19:0], 18'b0});
      ALU_ACC_ADD:
        acc_nxt = acc_r + prod_ext;
      ALU_ACC_SUB:
        acc_nxt = acc_sh21 - $signed({{(ACC_W-OFF_W){off_r[OFF_W-1]}}, off_r});
      ALU_TEMP_RES:
        res_nxt = $signed(temp_sh[RES_W-1:0] + TEMP_BASE);
      ALU_PRES_RES:
        res_nxt = acc_sh15[RES_W-1:0];
      default: ;
    endcase
  end

  // Hold the temperature difference across items
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      td_r <= '0;
    end else if (ctl.exec) begin
      td_r <= td_nxt;
    end
  end

  // Capture the item and advance the working registers
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      kind_r <= in_req_type;
      raw_r  <= in_raw_reading;
    end
    if (ctl.exec) begin
      prod_r <= prod_nxt;
      off_r  <= off_nxt;
      sens_r <= sens_nxt;
      acc_r  <= acc_nxt;
      res_r  <= res_nxt;
    end
    if (ctl.commit) begin
      res_kind_r <= kind_r;
    end
  end

endmodule

/* sv/baro_sensor_compensation.sv */
// Top level of the barometric sensor compensation block: sequencer and
// datapath. Depends on bsc_pkg, bsc_seq and bsc_dp.
//
// Usage:
//   Input items (in_req_type, in_raw_reading) arrive on a valid/ready channel.
//   A temperature item updates the stored temperature difference and returns
//   the temperature in centidegrees; a pressure item returns the compensated
//   pressure from the stored difference. Each item gives exactly one result
//   on the out_ channel, tagged with out_result_kind.
//   Coefficients are written through cfg_we/cfg_index/cfg_wdata while idle.
//   A temperature item runs 4 program steps, a pressure item 9; the result
//   is registered in the output register at the last step. One item is in
//   work at a time and in_ready rises the cycle after the last step, so a
//   new item is taken only once the last one is through, as the control
//   program shares a single 25 x 19 multiplier and one accumulator.
//   The result sits in an output register: the next item is accepted while
//   it waits, and a stalled receiver holds the next item at its last step.
//   Reset clears the coefficients, the stored difference and all control.
module baro_sensor_compensation (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [bsc_pkg::IDX_W-1:0]         cfg_index,
  input  logic [bsc_pkg::COEF_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_req_type,
  input  logic [bsc_pkg::RAW_W-1:0]         in_raw_reading,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_result_kind,
  output logic signed [bsc_pkg::RES_W-1:0]  out_result_value
);
  import bsc_pkg::*;

  dp_ctl_t ctl;
  logic    is_pres;

  bsc_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .is_pres   (is_pres),
    .ctl       (ctl)
  );

  bsc_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_req_type      (in_req_type),
    .in_raw_reading   (in_raw_reading),
    .ctl              (ctl),
    .is_pres          (is_pres),
    .out_result_kind  (out_result_kind),
    .out_result_value (out_result_value)
  );

endmodule
